### rtl/core/tbw_pkg.sv
// Shared constants for the triangle barycentric weight pipeline.
package tbw_pkg;

	localparam int DIV_INT_STEPS = 4;
	localparam int DIV_EXTRA_STAGES = 3;

endpackage

### rtl/core/tbw_if.sv
// Request and result channel interfaces of the barycentric weight block.
interface tbw_req_if #(
	parameter int COORD_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] vertex_a_x;
	logic signed [COORD_WIDTH-1:0] vertex_a_y;
	logic signed [COORD_WIDTH-1:0] vertex_b_x;
	logic signed [COORD_WIDTH-1:0] vertex_b_y;
	logic signed [COORD_WIDTH-1:0] vertex_c_x;
	logic signed [COORD_WIDTH-1:0] vertex_c_y;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;

	modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		vertex_c_x, vertex_c_y, point_x, point_y, input ready);
	modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		vertex_c_x, vertex_c_y, point_x, point_y, output ready);
endinterface

interface tbw_rsp_if #(
	parameter int WEIGHT_WIDTH = 18
);
	logic valid;
	logic ready;
	logic signed [WEIGHT_WIDTH-1:0] weight_a;
	logic signed [WEIGHT_WIDTH-1:0] weight_b;
	logic signed [WEIGHT_WIDTH-1:0] weight_c;
	logic degenerate;
	logic saturated;

	modport source (output valid, weight_a, weight_b, weight_c, degenerate, saturated,
		input ready);
	modport sink (input valid, weight_a, weight_b, weight_c, degenerate, saturated,
		output ready);
endinterface

### rtl/core/triangle_barycentric_weights.sv
// Top level of the triangle barycentric weight pipeline.
// Takes one request per clock unless a waiting result stalls the pipeline, and returns
// weight_a, weight_b and weight_c as signed fixed point with WEIGHT_FRAC_BITS fraction
// bits, plus degenerate and saturated flags. Three stages form the edge vectors, products
// and cross product, one stage takes magnitudes and the area test, and the divider
// registers its operands, resolves one quotient bit per stage over four integer and
// WEIGHT_FRAC_BITS + 1 fraction steps, and registers the rounded weight. The whole
// pipeline holds while a result waits.
module triangle_barycentric_weights import tbw_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int COORD_FRAC_BITS = 4,
	parameter int WEIGHT_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	tbw_req_if.sink request,
	tbw_rsp_if.source result
);
	localparam int CW = COORD_WIDTH;
	localparam int FB = WEIGHT_FRAC_BITS;
	localparam int NW = 2 * CW + 5;
	localparam int DL = DIV_INT_STEPS + FB + 1 + DIV_EXTRA_STAGES - 1;
	localparam int CROSS_STAGES = 3;
	localparam logic [15:0] THR_RESET = 16'(1 << (2 * COORD_FRAC_BITS));

	logic en;
	logic [15:0] thr_q;
	logic [CROSS_STAGES-1:0] vld_cross_q;
	logic signed [2*CW+2:0] ux, uy, uz;
	logic [NW-1:0] na_s4, nb_s4, nc_s4, d_s4;
	logic neg_a_s4, neg_b_s4, neg_c_s4, deg_s4, v_s4;
	logic [DL-1:0] vld_q, deg_q;
	logic signed [FB+3:0] wa, wb, wc;
	logic sat_a, sat_b, sat_c;

	assign en = !vld_q[DL-1] || result.ready;
	assign request.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	tbw_cross #(.CW(CW)) u_cross (
		.clk(clk), .en(en),
		.ax(request.vertex_a_x), .ay(request.vertex_a_y),
		.bx(request.vertex_b_x), .by(request.vertex_b_y),
		.cx(request.vertex_c_x), .cy(request.vertex_c_y),
		.px(request.point_x), .py(request.point_y),
		.ux(ux), .uy(uy), .uz(uz)
	);

	logic signed [NW-1:0] uz_w, na_w, nb_w, nc_w;
	assign uz_w = $signed({{2{uz[2*CW+2]}}, uz});
	assign nb_w = $signed({{2{uy[2*CW+2]}}, uy});
	assign nc_w = $signed({{2{ux[2*CW+2]}}, ux});
	assign na_w = uz_w - nc_w - nb_w;

	logic [NW-1:0] uz_mag;
	assign uz_mag = uz_w[NW-1] ? NW'(-uz_w) : NW'(uz_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_cross_q <= '0;
			v_s4 <= 1'b0;
			vld_q <= '0;
		end else if (en) begin
			vld_cross_q <= {vld_cross_q[CROSS_STAGES-2:0], request.valid};
			v_s4 <= vld_cross_q[CROSS_STAGES-1];
			vld_q <= {vld_q[DL-2:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s4 <= na_w[NW-1] ? NW'(-na_w) : NW'(na_w);
			nb_s4 <= nb_w[NW-1] ? NW'(-nb_w) : NW'(nb_w);
			nc_s4 <= nc_w[NW-1] ? NW'(-nc_w) : NW'(nc_w);
			d_s4 <= uz_mag;
			neg_a_s4 <= na_w[NW-1] ^ uz_w[NW-1];
			neg_b_s4 <= nb_w[NW-1] ^ uz_w[NW-1];
			neg_c_s4 <= nc_w[NW-1] ^ uz_w[NW-1];
			deg_s4 <= (uz_mag == '0) || (uz_mag < {{(NW-16){1'b0}}, thr_q});
			deg_q <= {deg_q[DL-2:0], deg_s4};
		end
	end

	logic [NW-1:0] d_div;
	assign d_div = deg_s4 ? {{(NW-1){1'b0}}, 1'b1} : d_s4;

	tbw_divider #(.NW(NW), .FB(FB)) u_div_a (
		.clk(clk), .en(en), .num_mag(na_s4), .den_mag(d_div), .neg(neg_a_s4),
		.weight(wa), .sat(sat_a)
	);
	tbw_divider #(.NW(NW), .FB(FB)) u_div_b (
		.clk(clk), .en(en), .num_mag(nb_s4), .den_mag(d_div), .neg(neg_b_s4),
		.weight(wb), .sat(sat_b)
	);
	tbw_divider #(.NW(NW), .FB(FB)) u_div_c (
		.clk(clk), .en(en), .num_mag(nc_s4), .den_mag(d_div), .neg(neg_c_s4),
		.weight(wc), .sat(sat_c)
	);

	logic signed [FB+3:0] minus_one;
	assign minus_one = $signed(-({{3{1'b0}}, 1'b1, {FB{1'b0}}}));

	assign result.valid = vld_q[DL-1];
	assign result.degenerate = deg_q[DL-1];
	assign result.weight_a = deg_q[DL-1] ? minus_one : wa;
	assign result.weight_b = deg_q[DL-1] ? minus_one : wb;
	assign result.weight_c = deg_q[DL-1] ? minus_one : wc;
	assign result.saturated = !deg_q[DL-1] && (sat_a || sat_b || sat_c);
endmodule

### rtl/core/tbw_cross.sv
// Edge vectors and their cross product over three pipeline stages.
module tbw_cross import tbw_pkg::*; #(
	parameter int CW = 16
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	output logic signed [2*CW+2:0] ux,
	output logic signed [2*CW+2:0] uy,
	output logic signed [2*CW+2:0] uz
);
	logic signed [CW:0] e0_s1, e1_s1, e2_s1, f0_s1, f1_s1, f2_s1;
	logic signed [2*CW+1:0] p_e1f2_s2, p_e2f1_s2, p_e2f0_s2, p_e0f2_s2, p_e0f1_s2, p_e1f0_s2;
	logic signed [2*CW+2:0] ux_s3, uy_s3, uz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1 <= $signed({cx[CW-1], cx}) - $signed({ax[CW-1], ax});
			e1_s1 <= $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
			e2_s1 <= $signed({ax[CW-1], ax}) - $signed({px[CW-1], px});
			f0_s1 <= $signed({cy[CW-1], cy}) - $signed({ay[CW-1], ay});
			f1_s1 <= $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
			f2_s1 <= $signed({ay[CW-1], ay}) - $signed({py[CW-1], py});
			p_e1f2_s2 <= e1_s1 * f2_s1;
			p_e2f1_s2 <= e2_s1 * f1_s1;
			p_e2f0_s2 <= e2_s1 * f0_s1;
			p_e0f2_s2 <= e0_s1 * f2_s1;
			p_e0f1_s2 <= e0_s1 * f1_s1;
			p_e1f0_s2 <= e1_s1 * f0_s1;
			ux_s3 <= $signed({p_e1f2_s2[2*CW+1], p_e1f2_s2})
				- $signed({p_e2f1_s2[2*CW+1], p_e2f1_s2});
			uy_s3 <= $signed({p_e2f0_s2[2*CW+1], p_e2f0_s2})
				- $signed({p_e0f2_s2[2*CW+1], p_e0f2_s2});
			uz_s3 <= $signed({p_e0f1_s2[2*CW+1], p_e0f1_s2})
				- $signed({p_e1f0_s2[2*CW+1], p_e1f0_s2});
		end
	end

	assign ux = ux_s3;
	assign uy = uy_s3;
	assign uz = uz_s3;
endmodule

### rtl/core/tbw_divider.sv
// Pipelined restoring divider giving one rounded, saturated signed weight.
module tbw_divider import tbw_pkg::*; #(
	parameter int NW = 37,
	parameter int FB = 14
) (
	input  logic clk,
	input  logic en,
	input  logic [NW-1:0] num_mag,
	input  logic [NW-1:0] den_mag,
	input  logic neg,
	output logic signed [FB+3:0] weight,
	output logic sat
);
	localparam int QW = FB + 5;
	localparam int STEPS = DIV_INT_STEPS + FB + 1;

	logic [NW:0] rem_s [0:STEPS];
	logic [NW-1:0] den_s [0:STEPS];
	logic [QW-1:0] quo_s [0:STEPS];
	logic neg_s [0:STEPS];
	logic big_s [0:STEPS];
	logic signed [FB+3:0] weight_q;
	logic sat_q;

	logic [NW+3:0] nine_den;
	assign nine_den = {1'b0, den_mag, 3'b000} + {4'b0000, den_mag};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, num_mag};
			den_s[0] <= den_mag;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			big_s[0] <= {4'b0000, num_mag} >= nine_den;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < STEPS; gi++) begin : g_step
			logic [NW+3:0] trial;
			logic [NW+3:0] dshift;
			logic take;
			logic [NW:0] rem_next;
			if (gi < DIV_INT_STEPS) begin : g_int
				assign trial = {3'b000, rem_s[gi]};
				assign dshift = {4'b0000, den_s[gi]} << (DIV_INT_STEPS - 1 - gi);
			end else begin : g_frac
				assign trial = {3'b000, rem_s[gi][NW-1:0], 1'b0};
				assign dshift = {4'b0000, den_s[gi]};
			end
			assign take = trial >= dshift;
			assign rem_next = take ? (trial[NW:0] - dshift[NW:0]) : trial[NW:0];
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gi+1] <= rem_next;
					den_s[gi+1] <= den_s[gi];
					quo_s[gi+1] <= {quo_s[gi][QW-2:0], take};
					neg_s[gi+1] <= neg_s[gi];
					big_s[gi+1] <= big_s[gi];
				end
			end
		end
	endgenerate

	logic [QW:0] rounded;
	logic [QW-1:0] mag;
	logic [QW-1:0] limit;
	logic [QW-1:0] mag_sel;
	logic over;
	assign rounded = {1'b0, quo_s[STEPS]} + {{QW{1'b0}}, 1'b1};
	assign mag = rounded[QW:1];
	assign limit = ({{(QW-1){1'b0}}, 1'b1} << (FB + 3))
		- {{(QW-1){1'b0}}, ~neg_s[STEPS]};
	assign over = big_s[STEPS] || (mag > limit);
	assign mag_sel = over ? limit : mag;

	always_ff @(posedge clk) begin
		if (en) begin
			weight_q <= neg_s[STEPS] ? $signed(-mag_sel[FB+3:0]) : $signed(mag_sel[FB+3:0]);
			sat_q <= over;
		end
	end

	assign weight = weight_q;
	assign sat = sat_q;
endmodule

### sim/testbench.sv
// Self-checking testbench for the triangle barycentric weight pipeline.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	localparam int WW = 18;
	localparam int FRAC = 14;
	localparam int LATENCY = FRAC + 11;

	typedef struct packed {
		logic signed [WW-1:0] weight_a;
		logic signed [WW-1:0] weight_b;
		logic signed [WW-1:0] weight_c;
		logic degenerate;
		logic saturated;
	} weights_t;

	class weight_scoreboard;
		weights_t pending[$];
		longint unsigned area_limit = 256;
		int errors = 0;
		int checked = 0;
		int degenerate_seen = 0;
		int saturated_seen = 0;

		function logic [WW-1:0] quotient(longint num, longint den, ref bit sat);
			bit neg;
			longint unsigned n, d, ip, r, q, mag, limit;
			neg = (num < 0) != (den < 0);
			n = num < 0 ? -num : num;
			d = den < 0 ? -den : den;
			ip = n / d;
			r = n % d;
			limit = (64'd1 << (FRAC + 3)) - (neg ? 0 : 1);
			if (ip > 8) begin
				mag = limit;
				sat = 1;
			end else begin
				q = ip;
				for (int i = 0; i < FRAC + 1; i++) begin
					r = r << 1;
					q = q << 1;
					if (r >= d) begin
						r = r - d;
						q = q | 1;
					end
				end
				mag = (q + 1) >> 1;
				if (mag > limit) begin
					mag = limit;
					sat = 1;
				end
			end
			return WW'(neg ? -mag : mag);
		endfunction

		function void note_request(logic signed [CW-1:0] c[8]);
			longint e0, e1, e2, f0, f1, f2, ux, uy, uz;
			bit sat;
			weights_t w;
			sat = 0;
			e0 = c[4] - c[0];
			e1 = c[2] - c[0];
			e2 = c[0] - c[6];
			f0 = c[5] - c[1];
			f1 = c[3] - c[1];
			f2 = c[1] - c[7];
			ux = e1 * f2 - e2 * f1;
			uy = e2 * f0 - e0 * f2;
			uz = e0 * f1 - e1 * f0;
			if (uz == 0 || longint'(uz < 0 ? -uz : uz) < longint'(area_limit)) begin
				w.weight_a = WW'(-(1 << FRAC));
				w.weight_b = WW'(-(1 << FRAC));
				w.weight_c = WW'(-(1 << FRAC));
				w.degenerate = 1;
				w.saturated = 0;
			end else begin
				w.weight_a = quotient(uz - ux - uy, uz, sat);
				w.weight_b = quotient(uy, uz, sat);
				w.weight_c = quotient(ux, uz, sat);
				w.degenerate = 0;
				w.saturated = sat;
			end
			pending.push_back(w);
		endfunction

		function void check_result(weights_t got);
			weights_t w;
			if (pending.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			w = pending.pop_front();
			checked++;
			if (got.degenerate) degenerate_seen++;
			if (got.saturated) saturated_seen++;
			if (got.weight_a !== w.weight_a) begin
				$error("weight_a expected %0d actual %0d", w.weight_a, got.weight_a);
				errors++;
			end
			if (got.weight_b !== w.weight_b) begin
				$error("weight_b expected %0d actual %0d", w.weight_b, got.weight_b);
				errors++;
			end
			if (got.weight_c !== w.weight_c) begin
				$error("weight_c expected %0d actual %0d", w.weight_c, got.weight_c);
				errors++;
			end
			if (got.degenerate !== w.degenerate) begin
				$error("degenerate expected %0d actual %0d", w.degenerate, got.degenerate);
				errors++;
			end
			if (got.saturated !== w.saturated) begin
				$error("saturated expected %0d actual %0d", w.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = 0;

	tbw_req_if #(.COORD_WIDTH(CW)) request();
	tbw_rsp_if #(.WEIGHT_WIDTH(WW)) result();

	triangle_barycentric_weights uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.request(request.sink),
		.result(result.source)
	);

	weight_scoreboard board = new();
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;
	int sent = 0;

	initial begin
		request.valid = 0;
		request.vertex_a_x = 0;
		request.vertex_a_y = 0;
		request.vertex_b_x = 0;
		request.vertex_b_y = 0;
		request.vertex_c_x = 0;
		request.vertex_c_y = 0;
		request.point_x = 0;
		request.point_y = 0;
		result.ready = 0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (request.valid && request.ready)
			board.note_request('{request.vertex_a_x, request.vertex_a_y,
				request.vertex_b_x, request.vertex_b_y, request.vertex_c_x,
				request.vertex_c_y, request.point_x, request.point_y});
		if (result.valid && result.ready)
			board.check_result('{result.weight_a, result.weight_b, result.weight_c,
				result.degenerate, result.saturated});
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function logic signed [CW-1:0] rand_coord(int spread);
		case ($urandom_range(3))
			0: return CW'($urandom);
			default: return CW'($signed($urandom_range(2 * spread)) - spread);
		endcase
	endfunction

	task automatic send_request(logic signed [CW-1:0] c[8]);
		while ($urandom_range(99) < send_idle) begin
			request.valid <= 0;
			@(posedge clk);
		end
		request.valid <= 1;
		request.vertex_a_x <= c[0];
		request.vertex_a_y <= c[1];
		request.vertex_b_x <= c[2];
		request.vertex_b_y <= c[3];
		request.vertex_c_x <= c[4];
		request.vertex_c_y <= c[5];
		request.point_x <= c[6];
		request.point_y <= c[7];
		do @(posedge clk); while (!request.ready);
		sent++;
	endtask

	task automatic drain_and_set(logic [15:0] threshold);
		request.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= threshold;
		@(posedge clk);
		cfg_we <= 0;
		board.area_limit = threshold;
		@(posedge clk);
	endtask

	task automatic random_phase(int count, int idle, int stall);
		logic signed [CW-1:0] c[8];
		int spread;
		send_idle = idle;
		recv_stall = stall;
		for (int n = 0; n < count; n++) begin
			spread = $urandom_range(3) == 0 ? 32767 : (1 << $urandom_range(12, 4));
			foreach (c[i]) c[i] = rand_coord(spread);
			if ($urandom_range(9) == 0) begin
				c[4] = CW'(c[0] + (c[2] - c[0]) * $signed($urandom_range(4)));
				c[5] = CW'(c[1] + (c[3] - c[1]) * $signed($urandom_range(4)));
			end
			send_request(c);
		end
	endtask

	initial begin
		logic signed [CW-1:0] c[8];
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_idle = 0;
		recv_stall = 0;
		send_request('{0, 0, 16, 0, 0, 16, 4, 4});
		send_request('{0, 0, 16, 0, 0, 16, 0, 0});
		send_request('{0, 0, 16, 0, 0, 16, 16, 0});
		send_request('{0, 0, 16, 0, 0, 16, 32767, -32768});
		send_request('{0, 0, 16, 0, 32, 0, 5, 5});
		send_request('{7, 7, 7, 7, 7, 7, 7, 7});
		send_request('{0, 0, 1, 0, 0, 1, 0, 0});
		send_request('{-32768, -32768, 32767, -32768, -32768, 32767, 0, 0});
		send_request('{32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767});
		send_request('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767});
		send_request('{0, 0, 16, 0, 0, -16, 3, -5});
		send_request('{0, 0, 16, 0, 0, 16, -1, -1});
		drain_and_set(0);
		send_request('{0, 0, 16, 0, 32, 0, 1, 1});
		send_request('{0, 0, 1, 0, 0, 1, -32768, 32767});
		drain_and_set(16'hFFFF);
		send_request('{0, 0, 256, 0, 0, 255, 1, 1});
		send_request('{0, 0, 256, 0, 0, 256, 1, 1});
		drain_and_set(256);
		random_phase(400, 0, 0);
		hold_off = 300;
		random_phase(100, 0, 0);
		random_phase(300, 52, 0);
		drain_and_set(16'($urandom_range(65535)));
		random_phase(300, 0, 52);
		drain_and_set(0);
		random_phase(300, 30, 30);
		drain_and_set(1);
		random_phase(200, 0, 0);
		request.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d requests over five thresholds and four idling mixes.", sent);
		$display("Checked %0d results, %0d degenerate, %0d saturated.",
			board.checked, board.degenerate_seen, board.saturated_seen);
		if (board.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#2ms;
		$display("testbench: FAIL");
		$finish;
	end
endmodule
